// ----- src/dertlv_pkg.sv -----
// ----------------------------------------------------------------------------
// DER TLV parser package
// Shared constants, codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package dertlv_pkg;

  localparam int MAX_DEPTH       = 16;
  localparam int TAG_BYTES_LIMIT = 6;
  localparam int LEN_BYTES_LIMIT = 5;
  localparam int LVL_W           = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W           = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Result kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_EOS     = 3'd0;
  localparam logic [2:0] ERR_OVERRUN = 3'd1;
  localparam logic [2:0] ERR_TAG     = 3'd2;
  localparam logic [2:0] ERR_LENLEN  = 3'd3;
  localparam logic [2:0] ERR_INDEF   = 3'd4;
  localparam logic [2:0] ERR_DEEP    = 3'd5;

  // Universal type table: 0 primitive only, 1 constructed only, 2 either, 3 none
  localparam logic [1:0] UNIV_KIND [32] = '{
    2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd2,
    2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd3, 2'd3,
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3
  };

  // Parser phase
  typedef enum logic [2:0] {
    PH_ID, PH_TAG, PH_LEN1, PH_LENN, PH_DATA
  } phase_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic       byte_en;   // process in_byte in current phase
    logic       pop;       // pop one stack level
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic       in_id;     // phase is awaiting identifier
    logic       top_match; // top-of-stack end equals stream offset
    logic       lvl_zero;
    logic       halted;
  } dp_sts_t;

endpackage

// ----- src/dertlv_datapath.sv -----
// ----------------------------------------------------------------------------
// DER TLV datapath
// Header decode registers, end-offset stack and result formatting.
// ----------------------------------------------------------------------------
module dertlv_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dertlv_pkg::dp_cmd_t   cmd,
  input  logic [7:0]            in_b,
  output dertlv_pkg::dp_sts_t   sts,
  // result slot 0 produced by a byte
  output logic                  r0_v,
  output logic [1:0]            r0_kind,
  output logic [2:0]            r0_err,
  output logic [31:0]           r0_off,
  output logic [7:0]            r0_byte,
  output logic                  r0_last,
  output logic [1:0]            r0_cls,
  output logic                  r0_cons,
  output logic [27:0]           r0_tag,
  output logic [31:0]           r0_clen,
  output logic [3:0]            r0_hlen,
  output logic [1:0]            r0_warn,
  output logic [4:0]            depth
);
  import dertlv_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [27:0]       tag_r, tag_nxt;
  logic [3:0]        tcnt_r, tcnt_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [3:0]        lleft_r, lleft_nxt;
  logic [31:0]       cleft_r, cleft_nxt;
  logic [31:0]       off_r;
  logic [31:0]       start_r, start_nxt;
  logic [1:0]        cls_r, cls_nxt;
  logic              cons_r, cons_nxt;
  logic [1:0]        warn_r, warn_nxt;
  logic [4:0]        hcnt_r, hcnt_nxt;
  logic [LVL_W-1:0]  lvl_r;
  logic              halt_r;
  logic [31:0]       stk [MAX_DEPTH];
  logic [31:0]       top;
  logic              push;
  logic [31:0]       push_val;
  logic              fin;         // header completes on this byte
  logic              err;
  logic [2:0]        ecode;
  logic [32:0]       endv;
  logic [31:0]       off_inc;
  logic              hdr_ok;
  logic              dat;
  logic [31:0]       cdec;

  assign top     = stk[IDX_W'(lvl_r - LVL_W'(1))];
  assign off_inc = off_r + 32'd1;
  assign depth   = (lvl_r > LVL_W'(31)) ? 5'd31 : 5'(lvl_r);

  // Header end computation
  always_comb begin
    endv = {1'b0, off_r} + 33'd1 + {1'b0, len_nxt};
  end

  // Per-byte decode
  always_comb begin
    logic [1:0] uk;
    phase_nxt = phase_r; tag_nxt = tag_r; tcnt_nxt = tcnt_r; len_nxt = len_r;
    lleft_nxt = lleft_r; cleft_nxt = cleft_r; start_nxt = start_r;
    cls_nxt = cls_r; cons_nxt = cons_r; warn_nxt = warn_r; hcnt_nxt = hcnt_r;
    fin = 1'b0; err = 1'b0; ecode = ERR_EOS; dat = 1'b0; cdec = cleft_r;
    uk = UNIV_KIND[in_b[4:0]];
    case (phase_r)
      PH_ID: begin
        cls_nxt = in_b[7:6]; cons_nxt = in_b[5]; warn_nxt = 2'b00;
        if (in_b[7:6] == 2'd0 && uk[1] == 1'b0 && in_b[5] != uk[0]) begin
          cons_nxt = 1'b0; warn_nxt = 2'b01;
        end
        start_nxt = off_r; tcnt_nxt = 4'd1; hcnt_nxt = 5'd1; len_nxt = '0;
        if (in_b[4:0] == 5'h1F) begin
          tag_nxt = '0; phase_nxt = PH_TAG;
        end else begin
          tag_nxt = 28'(in_b[4:0]); phase_nxt = PH_LEN1;
        end
      end
      PH_TAG: begin
        tag_nxt = {tag_r[20:0], in_b[6:0]};
        tcnt_nxt = tcnt_r + 4'd1;
        hcnt_nxt = hcnt_r + 5'd1;
        if (tcnt_nxt >= 4'(TAG_BYTES_LIMIT)) begin
          err = 1'b1; ecode = ERR_TAG;
        end else if (!in_b[7]) begin
          if (cls_r == 2'd0 && tag_nxt >= 28'd31) warn_nxt = warn_r | 2'b10;
          phase_nxt = PH_LEN1;
        end
      end
      PH_LEN1: begin
        hcnt_nxt = hcnt_r + 5'd1;
        if (in_b[7]) begin
          if (in_b[6:0] > 7'(LEN_BYTES_LIMIT - 1)) begin
            err = 1'b1; ecode = ERR_LENLEN;
          end else if (in_b[6:0] == 7'd0) begin
            err = 1'b1; ecode = ERR_INDEF;
          end else begin
            len_nxt = '0; lleft_nxt = 4'(in_b[3:0]); phase_nxt = PH_LENN;
          end
        end else begin
          len_nxt = 32'(in_b); fin = 1'b1;
        end
      end
      PH_LENN: begin
        hcnt_nxt = hcnt_r + 5'd1;
        if (len_r[31:24] != 8'd0) begin
          err = 1'b1; ecode = ERR_LENLEN;
        end else begin
          len_nxt = {len_r[23:0], in_b};
          if (lleft_r != 4'd0) lleft_nxt = lleft_r - 4'd1;
          if (lleft_nxt == 4'd0) fin = 1'b1;
        end
      end
      default: begin
        dat = 1'b1;
        if (cleft_r != 32'd0) cdec = cleft_r - 32'd1;
        cleft_nxt = cdec;
        if (cdec == 32'd0) phase_nxt = PH_ID;
      end
    endcase
    // header completion checks
    hdr_ok = 1'b0;
    push = 1'b0;
    if (fin) begin
      if (endv[32]) begin
        err = 1'b1; ecode = ERR_OVERRUN;
      end else if (lvl_r != '0 && endv[31:0] > top) begin
        err = 1'b1; ecode = ERR_OVERRUN;
      end else if (cons_r && lvl_r >= LVL_W'(MAX_DEPTH)) begin
        err = 1'b1; ecode = ERR_DEEP;
      end else begin
        hdr_ok = 1'b1;
        if (cons_r) begin
          push = 1'b1; phase_nxt = PH_ID;
        end else if (len_nxt != 32'd0) begin
          cleft_nxt = len_nxt; phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_ID;
        end
      end
    end
    push_val = endv[31:0];
  end

  // Slot 0: header, data or error from the byte itself.
  // Clean end / end-of-stream error is handled by the controller after pops.
  always_comb begin
    r0_v = cmd.byte_en && (err || hdr_ok || dat);
    r0_kind = err ? KIND_ERR : (dat ? KIND_DATA : KIND_HDR);
    r0_err  = err ? ecode : 3'd0;
    r0_off  = err ? off_r : start_r;
    r0_byte = dat ? in_b : 8'd0;
    r0_last = dat && cdec == 32'd0;
    r0_cls  = (hdr_ok && !err) ? cls_r : 2'd0;
    r0_cons = (hdr_ok && !err) ? cons_r : 1'b0;
    r0_tag  = (hdr_ok && !err) ? tag_nxt : 28'd0;
    r0_clen = (hdr_ok && !err) ? len_nxt : 32'd0;
    r0_hlen = (hdr_ok && !err) ? ((hcnt_nxt > 5'd15) ? 4'd15 : hcnt_nxt[3:0]) : 4'd0;
    r0_warn = (hdr_ok && !err) ? warn_nxt : 2'd0;
  end

  // Status to controller
  assign sts.in_id     = phase_r == PH_ID;
  assign sts.top_match = lvl_r != '0 && top == off_r;
  assign sts.lvl_zero  = lvl_r == '0;
  assign sts.halted    = halt_r;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID; tag_r <= '0; tcnt_r <= '0; len_r <= '0; lleft_r <= '0;
      cleft_r <= '0; off_r <= '0; start_r <= '0; cls_r <= '0; cons_r <= 1'b0;
      warn_r <= '0; hcnt_r <= '0; lvl_r <= '0; halt_r <= 1'b0;
    end else if (cmd.byte_en) begin
      phase_r <= phase_nxt; tag_r <= tag_nxt; tcnt_r <= tcnt_nxt; len_r <= len_nxt;
      lleft_r <= lleft_nxt; cleft_r <= cleft_nxt; start_r <= start_nxt;
      cls_r <= cls_nxt; cons_r <= cons_nxt; warn_r <= warn_nxt; hcnt_r <= hcnt_nxt;
      off_r <= off_inc;
      if (push) lvl_r <= lvl_r + LVL_W'(1);
      if (err) halt_r <= 1'b1;
    end else if (cmd.pop) begin
      lvl_r <= lvl_r - LVL_W'(1);
    end
  end

  // End-offset stack
  always_ff @(posedge clk) begin
    if (cmd.byte_en && push) stk[IDX_W'(lvl_r)] <= push_val;
  end

endmodule

// ----- src/dertlv_ctrl.sv -----
// ----------------------------------------------------------------------------
// DER TLV controller
// Sequences byte decode, stack pops and stream-end result; owns the output valid flag.
// ----------------------------------------------------------------------------
module dertlv_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_is_last,
  input  logic                 out_stall,
  output logic                 out_valid,
  output dertlv_pkg::dp_cmd_t  cmd,
  input  dertlv_pkg::dp_sts_t  sts,
  input  logic                 r0_v,
  output logic                 load_r0,
  output logic                 load_end,
  output logic                 end_err
);
  import dertlv_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_OUT0, S_POP, S_END, S_DONE} st_t;

  st_t  st_r;
  logic last_r;
  logic ov_r;

  assign out_valid = ov_r;
  assign in_stall  = !(st_r == S_IDLE && !ov_r);

  always_comb begin
    cmd.byte_en = st_r == S_IDLE && !ov_r && in_valid;
    cmd.pop     = st_r == S_POP && sts.in_id && !sts.halted && sts.top_match;
    load_r0     = cmd.byte_en && r0_v;
    load_end    = st_r == S_END && !ov_r;
    end_err     = !(sts.in_id && sts.lvl_zero);
  end

  // Controller state and output-valid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; last_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (cmd.byte_en) begin
          last_r <= in_is_last;
          if (r0_v) ov_r <= 1'b1;
          st_r <= S_POP;
        end
        S_POP: begin
          if (sts.halted) st_r <= S_DONE;
          else if (!cmd.pop) st_r <= last_r ? S_END : S_IDLE;
        end
        S_END: if (!ov_r || !out_stall) begin
          if (!ov_r) begin ov_r <= 1'b1; st_r <= S_DONE; end
        end
        S_DONE: st_r <= S_DONE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/der_tlv_stream_parser_core.sv -----
// ----------------------------------------------------------------------------
// DER TLV stream parser core
// Decodes DER identifier and length octets; emits header, content-byte, end and error results.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in_     | in        | in_valid / in_stall, fields in_byte, in_is_last
// out_    | out       | out_valid / out_stall, one port per result field
// Each byte is decoded, then each nesting level closed at its offset is
// popped (stack pops); the last byte also produces the stream-end result.
// The single output register holds one result; a byte is not taken while it
// is full. Reset is synchronous, active low. After an error or a clean end
// the block takes no more bytes until reset.
module der_tlv_stream_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_id_class,
  output logic        out_constructed,
  output logic [27:0] out_tag_value,
  output logic [31:0] out_content_length,
  output logic [3:0]  out_header_length,
  output logic [4:0]  out_nest_depth,
  output logic [31:0] out_byte_offset,
  output logic [7:0]  out_content_byte,
  output logic        out_element_last,
  output logic [2:0]  out_error_code,
  output logic [1:0]  out_warnings
);
  import dertlv_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic r0_v, load_r0, load_end, end_err;
  logic [1:0] r0_kind, r0_cls, r0_warn;
  logic [2:0] r0_err;
  logic [31:0] r0_off, r0_clen;
  logic [7:0] r0_byte;
  logic r0_last, r0_cons;
  logic [27:0] r0_tag;
  logic [3:0] r0_hlen;
  logic [4:0] depth;
  logic [31:0] off_r;

  dertlv_datapath u_dp (
    .clk, .rst_n, .cmd, .in_b(in_byte), .sts,
    .r0_v, .r0_kind, .r0_err, .r0_off, .r0_byte, .r0_last, .r0_cls,
    .r0_cons, .r0_tag, .r0_clen, .r0_hlen, .r0_warn, .depth
  );

  dertlv_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_is_last, .out_stall, .out_valid,
    .cmd, .sts, .r0_v, .load_r0, .load_end, .end_err
  );

  // Track stream offset for the end result
  always_ff @(posedge clk) begin
    if (!rst_n) off_r <= '0;
    else if (cmd.byte_en) off_r <= off_r + 32'd1;
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load_r0) begin
      out_kind <= r0_kind; out_id_class <= r0_cls; out_constructed <= r0_cons;
      out_tag_value <= r0_tag; out_content_length <= r0_clen;
      out_header_length <= r0_hlen; out_nest_depth <= depth;
      out_byte_offset <= r0_off; out_content_byte <= r0_byte;
      out_element_last <= r0_last; out_error_code <= r0_err;
      out_warnings <= r0_warn;
    end else if (load_end) begin
      out_kind <= end_err ? KIND_ERR : KIND_END;
      out_id_class <= '0; out_constructed <= 1'b0; out_tag_value <= '0;
      out_content_length <= '0; out_header_length <= '0;
      out_nest_depth <= end_err ? depth : 5'd0;
      out_byte_offset <= off_r; out_content_byte <= '0;
      out_element_last <= 1'b0; out_error_code <= ERR_EOS; out_warnings <= '0;
    end
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// DER TLV stream parser testbench
// Feeds one long DER stream (directed elements, then random nested trees) into
// the parser with random idling on both sides. The stream ends cleanly or with
// one randomly chosen error. Every result is checked against a local model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dertlv_pkg::*;

  typedef byte unsigned bq_t[$];

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  id_class;
    logic        constructed;
    logic [27:0] tag_value;
    logic [31:0] content_length;
    logic [3:0]  header_length;
    logic [4:0]  nest_depth;
    logic [31:0] byte_offset;
    logic [7:0]  content_byte;
    logic        element_last;
    logic [2:0]  error_code;
    logic [1:0]  warnings;
  } rec_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_byte = 0;
  logic        in_is_last = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_kind;
  logic [1:0]  out_id_class;
  logic        out_constructed;
  logic [27:0] out_tag_value;
  logic [31:0] out_content_length;
  logic [3:0]  out_header_length;
  logic [4:0]  out_nest_depth;
  logic [31:0] out_byte_offset;
  logic [7:0]  out_content_byte;
  logic        out_element_last;
  logic [2:0]  out_error_code;
  logic [1:0]  out_warnings;

  der_tlv_stream_parser_core uut (.*);

  always #5 clk = ~clk;

  // stream bytes to send, indexed by n_sent
  bq_t         stream_q;
  int          n_total, n_sent, n_acc, n_res, n_err_seen;
  rec_t        parse_exp_q[$];
  int          errors;
  logic [2:0]  tail_kind;

  // parser state mirror
  phase_t      ph;
  logic [27:0] tag_acc;
  int          tag_cnt, hdr_cnt, len_left;
  logic [31:0] len_acc, data_left, offs, el_start;
  logic [1:0]  el_class;
  logic        el_cons;
  logic [1:0]  el_warn;
  logic [31:0] end_stack[MAX_DEPTH];
  int          lvl;
  logic        stopped;

  function automatic logic [4:0] depth_now();
    return (lvl > 31) ? 5'd31 : lvl[4:0];
  endfunction

  function automatic void push_err(logic [2:0] code, logic [31:0] off);
    rec_t r;
    r = '0;
    r.kind = KIND_ERR;
    r.error_code = code;
    r.byte_offset = off;
    r.nest_depth = depth_now();
    parse_exp_q.push_back(r);
    stopped = 1;
  endfunction

  function automatic void close_header(logic [31:0] cur);
    logic [32:0] fin;
    rec_t r;
    fin = {1'b0, cur} + 33'd1 + {1'b0, len_acc};
    if (fin[32]) push_err(ERR_OVERRUN, cur);
    else if (lvl > 0 && fin[31:0] > end_stack[lvl-1]) push_err(ERR_OVERRUN, cur);
    else if (el_cons && lvl >= MAX_DEPTH) push_err(ERR_DEEP, cur);
    else begin
      r = '0;
      r.kind = KIND_HDR;
      r.id_class = el_class;
      r.constructed = el_cons;
      r.tag_value = tag_acc;
      r.content_length = len_acc;
      r.header_length = (hdr_cnt > 15) ? 4'd15 : hdr_cnt[3:0];
      r.nest_depth = depth_now();
      r.byte_offset = el_start;
      r.warnings = el_warn;
      parse_exp_q.push_back(r);
      if (el_cons) begin
        end_stack[lvl] = fin[31:0];
        lvl++;
        ph = PH_ID;
      end else if (len_acc != 0) begin
        data_left = len_acc;
        ph = PH_DATA;
      end else ph = PH_ID;
    end
  endfunction

  // Advance the parser mirror by one accepted byte
  function automatic void parse_byte(logic [7:0] b, logic last);
    logic [31:0] cur;
    logic [1:0]  tk;
    rec_t r;
    cur = offs;
    if (stopped) return;
    case (ph)
      PH_ID: begin
        el_class = b[7:6];
        el_cons = b[5];
        el_warn = 0;
        tk = UNIV_KIND[b[4:0]];
        if (b[7:6] == 0 && tk < 2 && el_cons != tk[0]) begin
          el_cons = 0;
          el_warn[0] = 1;
        end
        el_start = cur;
        tag_cnt = 1;
        hdr_cnt = 1;
        len_acc = 0;
        if (b[4:0] == 5'h1F) begin
          tag_acc = 0;
          ph = PH_TAG;
        end else begin
          tag_acc = 28'(b[4:0]);
          ph = PH_LEN1;
        end
      end
      PH_TAG: begin
        tag_acc = {tag_acc[20:0], b[6:0]};
        tag_cnt++;
        hdr_cnt++;
        if (tag_cnt >= TAG_BYTES_LIMIT) push_err(ERR_TAG, cur);
        else if (!b[7]) begin
          if (el_class == 0 && tag_acc >= 31) el_warn[1] = 1;
          ph = PH_LEN1;
        end
      end
      PH_LEN1: begin
        hdr_cnt++;
        if (b[7]) begin
          if (b[6:0] > LEN_BYTES_LIMIT - 1) push_err(ERR_LENLEN, cur);
          else if (b[6:0] == 0) push_err(ERR_INDEF, cur);
          else begin
            len_acc = 0;
            len_left = int'(b[6:0]);
            ph = PH_LENN;
          end
        end else begin
          len_acc = 32'(b);
          close_header(cur);
        end
      end
      PH_LENN: begin
        hdr_cnt++;
        if (len_acc[31:24] != 0) push_err(ERR_LENLEN, cur);
        else begin
          len_acc = {len_acc[23:0], b};
          if (len_left > 0) len_left--;
          if (len_left == 0) close_header(cur);
        end
      end
      default: begin
        if (data_left > 0) data_left--;
        r = '0;
        r.kind = KIND_DATA;
        r.content_byte = b;
        r.element_last = (data_left == 0);
        r.nest_depth = depth_now();
        r.byte_offset = el_start;
        parse_exp_q.push_back(r);
        if (data_left == 0) ph = PH_ID;
      end
    endcase
    offs = cur + 32'd1;
    if (!stopped && ph == PH_ID)
      while (lvl > 0 && end_stack[lvl-1] == offs) lvl--;
    if (!stopped && last) begin
      if (ph == PH_ID && lvl == 0) begin
        r = '0;
        r.kind = KIND_END;
        r.byte_offset = offs;
        parse_exp_q.push_back(r);
        stopped = 1;
      end else push_err(ERR_EOS, offs);
    end
  endfunction

  // ---- stream generation ----
  function automatic bq_t enc_len(int n, bit force_long);
    bq_t q;
    int nb;
    if (n < 128 && !force_long) q.push_back(n[7:0]);
    else begin
      nb = (n > 'hFFFFFF) ? 4 : (n > 'hFFFF) ? 3 : (n > 'hFF) ? 2 : 1;
      if (force_long && nb < 4) nb = $urandom_range(nb, 4);
      q.push_back(8'h80 | nb[7:0]);
      for (int i = nb - 1; i >= 0; i--) q.push_back(8'((n >> (8 * i)) & 'hFF));
    end
    return q;
  endfunction

  // Identifier octets; returns whether the element is parsed as constructed
  function automatic bit enc_id(ref bq_t q, input bit want_cons);
    logic [1:0] cls, tk;
    logic [4:0] num;
    int nt;
    logic [27:0] tv;
    cls = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0) begin
      nt = $urandom_range(1, TAG_BYTES_LIMIT - 2);
      tv = 28'($urandom);
      q.push_back({cls, want_cons, 5'h1F});
      for (int i = nt - 1; i >= 0; i--)
        q.push_back({(i != 0), 7'(tv >> (7 * i))});
      return want_cons;
    end
    num = 5'($urandom_range(0, 30));
    q.push_back({cls, want_cons, num});
    tk = UNIV_KIND[num];
    if (cls == 0 && tk < 2 && want_cons != tk[0]) return 0;
    return want_cons;
  endfunction

  function automatic bq_t gen_elem(int depth);
    bq_t q, body, hl;
    bit cons;
    int n;
    cons = enc_id(q, (depth < 5) && ($urandom_range(0, 2) == 0));
    if (cons) begin
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) body = {body, gen_elem(depth + 1)};
    end else begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 8);
      for (int i = 0; i < n; i++) body.push_back(8'($urandom));
    end
    hl = enc_len(body.size(), $urandom_range(0, 5) == 0);
    return {q, hl, body};
  endfunction

  // n nested SEQUENCEs wrapping one primitive
  function automatic bq_t gen_chain(int n);
    bq_t q;
    if (n == 0) return '{8'h04, 8'h02, 8'h00, 8'hFF};
    q = gen_chain(n - 1);
    return {8'h30, 8'(q.size()), q};
  endfunction

  function automatic void build_stream();
    bq_t t;
    // directed: extremes of fields and warnings
    stream_q = {8'h05, 8'h00};                              // NULL, empty
    stream_q = {stream_q, 8'h21, 8'h01, 8'hAA};              // BOOLEAN marked constructed
    stream_q = {stream_q, 8'h10, 8'h00};                     // SEQUENCE marked primitive
    stream_q = {stream_q, 8'hFF, 8'h8F, 8'hFF, 8'hFF, 8'h7F, 8'h00}; // private long tag
    stream_q = {stream_q, 8'h1F, 8'h1F, 8'h00};              // universal long tag 31
    stream_q = {stream_q, 8'h9E, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'h55};
    stream_q = {stream_q, gen_chain(MAX_DEPTH)};
    // random trees
    while (stream_q.size() < 1240) stream_q = {stream_q, gen_elem(0)};
    tail_kind = 3'($urandom_range(0, 6));
    case (tail_kind)
      0: t = '{8'h02};                                        // truncated header
      1: t = '{8'h30, 8'h02, 8'h04, 8'h05};                   // child overruns parent
      2: t = '{8'h1F, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81};     // tag too long
      3: t = '{8'h02, 8'h85};                                 // too many length bytes
      4: t = '{8'h30, 8'h80};                                 // indefinite form
      5: begin                                               // nesting too deep
        for (int i = 0; i <= MAX_DEPTH; i++) begin
          t.push_back(8'h30);
          t.push_back(8'(100 - 2 * i));
        end
      end
      default: t = '{};                                      // clean end
    endcase
    stream_q = {stream_q, t};
    n_total = stream_q.size();
  endfunction

  // ---- driver ----
  int  in_gap, hold_cnt;
  bit  paused_done;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && n_acc < n_sent) begin
        // item still on offer
      end else if (in_gap > 0) begin
        in_valid <= 0;
        in_gap <= in_gap - 1;
      end else if (!paused_done && n_sent == 600 && parse_exp_q.size() != 0) begin
        in_valid <= 0;
      end else if (n_sent < n_total) begin
        if (n_sent == 600) paused_done <= 1;
        in_valid <= 1;
        in_byte <= stream_q[n_sent];
        in_is_last <= (n_sent == n_total - 1);
        n_sent <= n_sent + 1;
        if (n_sent < 1100 && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 7);
      end else in_valid <= 0;
    end
  end

  // acceptance and prediction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      parse_byte(in_byte, in_is_last);
      n_acc <= n_acc + 1;
    end
  end

  // ---- result side stall ----
  int out_gap;
  bit long_hold_done;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cnt > 0) begin
        out_stall <= 1;
        hold_cnt <= hold_cnt - 1;
      end else if (!long_hold_done && n_acc >= 300) begin
        long_hold_done <= 1;
        hold_cnt <= 150;
        out_stall <= 1;
      end else if (out_gap > 0) begin
        out_stall <= 1;
        out_gap <= out_gap - 1;
      end else if (n_acc < 1100 && $urandom_range(0, 9) == 0) begin
        out_stall <= 1;
        out_gap <= $urandom_range(0, 6);
      end else out_stall <= 0;
    end
  end

  // ---- result check ----
  always @(posedge clk) begin
    rec_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_kind, out_id_class, out_constructed, out_tag_value,
              out_content_length, out_header_length, out_nest_depth,
              out_byte_offset, out_content_byte, out_element_last,
              out_error_code, out_warnings};
      n_res++;
      if (out_kind == KIND_ERR) n_err_seen++;
      if (parse_exp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = parse_exp_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
          $display("  kind %0d/%0d tag %0d/%0d len %0d/%0d off %0d/%0d byte %h/%h err %0d/%0d",
                   want.kind, got.kind, want.tag_value, got.tag_value,
                   want.content_length, got.content_length, want.byte_offset,
                   got.byte_offset, want.content_byte, got.content_byte,
                   want.error_code, got.error_code);
          errors++;
        end
      end
    end
  end

  // ---- sequence ----
  initial begin
    ph = PH_ID; tag_acc = 0; tag_cnt = 0; hdr_cnt = 0; len_left = 0;
    len_acc = 0; data_left = 0; offs = 0; el_start = 0; el_class = 0;
    el_cons = 0; el_warn = 0; lvl = 0; stopped = 0;
    build_stream();
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1;
    wait (n_acc == n_total);
    wait (parse_exp_q.size() == 0);
    repeat (40) @(posedge clk);
    $display("Parsed %0d bytes, checked %0d results; stream tail case %0d, %0d error result(s).",
             n_acc, n_res, tail_kind, n_err_seen);
    if (errors == 0 && parse_exp_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule

// ----- der_tlv_stream_parser_core.f -----
src/dertlv_pkg.sv
src/dertlv_datapath.sv
src/dertlv_ctrl.sv
src/der_tlv_stream_parser_core.sv
verif/tb.sv
